/* design/ssseg_pkg.sv */
// Shared types and constants of the silence split segmenter.
// No dependencies; every other design file imports this package.
package ssseg_pkg;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_BITS    = 16;
    localparam int THR_BITS       = 16;
    localparam int LEN_BITS       = 24;
    localparam int OUT_BITS       = 32;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 2;

    // Default width of the sample index counters.
    localparam int DEF_INDEX_BITS = 32;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = 2;

    // Register reset values.
    localparam logic [THR_BITS-1:0] RST_THRESHOLD    = THR_BITS'(33);
    localparam logic [LEN_BITS-1:0] RST_MIN_SILENCE  = LEN_BITS'(66150);
    localparam logic [LEN_BITS-1:0] RST_KEEP_SILENCE = LEN_BITS'(11025);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_MIN_SILENCE  = 2'd1,
        CFG_KEEP_SILENCE = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [THR_BITS-1:0] threshold;
        logic [LEN_BITS-1:0] min_silence;
        logic [LEN_BITS-1:0] keep_silence;
    } t_cfg;

    typedef struct packed {
        logic [OUT_BITS-1:0] seg_start;
        logic [OUT_BITS-1:0] seg_end;
        logic                last_chunk;
    } t_chunk;

    // Up to two chunks are produced by one sample; first is written first.
    typedef struct packed {
        logic [1:0] count;
        t_chunk     first;
        t_chunk     second;
    } t_chunk_push;

endpackage

/* design/ssseg_if.sv */
// Valid/ready channel interfaces for samples in and chunk boundaries out.
// Depends on ssseg_pkg for the field widths.
interface ssseg_sample_if import ssseg_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] audio_sample;
    logic                          end_of_stream;

    modport source (output valid, output audio_sample, output end_of_stream, input ready);
    modport sink   (input valid, input audio_sample, input end_of_stream, output ready);
endinterface

interface ssseg_chunk_if import ssseg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] seg_start;
    logic [OUT_BITS-1:0] seg_end;
    logic                last_chunk;

    modport source (output valid, output seg_start, output seg_end,
                    output last_chunk, input ready);
    modport sink   (input valid, input seg_start, input seg_end,
                    input last_chunk, output ready);
endinterface

/* design/ssseg_core.sv */
// Per-sample silence tracking and chunk boundary generation.
// Depends on ssseg_pkg; holds the stream state and emits up to two chunks.
module ssseg_core import ssseg_pkg::*; #(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_fire,
    input  logic signed [SAMPLE_BITS-1:0] i_audio_sample,
    input  logic                          i_end_of_stream,
    output t_chunk_push                   o_push
);

    localparam int W  = INDEX_BITS;
    localparam int CW = ((W > LEN_BITS) ? W : LEN_BITS) + 1;
    localparam logic [CW-1:0] IDX_MAX = CW'({W{1'b1}});

    logic [W-1:0] r_sample_index, n_sample_index;
    logic         r_in_silence, n_in_silence;
    logic [W-1:0] r_silence_start, n_silence_start;
    logic [W-1:0] r_resume_point, n_resume_point;
    logic         r_any_chunk_sent, n_any_chunk_sent;

    logic [SAMPLE_BITS:0] sext, mag;
    logic          silent;
    logic [W-1:0]  idx_next, start_eff, run_len_mid, run_len_tail, run_end;
    logic          close_mid, close_tail, do_close, emit_close, emit_final, final_span;
    logic [CW-1:0] ce_sum, ce_sat, end_wide;
    logic [W-1:0]  ce, ce_out, resume_new, resume_after, final_start;
    logic          any_after;
    t_chunk        close_c, final_c;

    always_comb begin
        sext = {i_audio_sample[SAMPLE_BITS-1], i_audio_sample};
        mag  = i_audio_sample[SAMPLE_BITS-1] ? (~sext + 1'b1) : sext;
        silent = mag < {1'b0, i_cfg.threshold};

        idx_next    = r_sample_index + 1'b1;
        start_eff   = (!r_in_silence && silent) ? r_sample_index : r_silence_start;
        run_len_mid  = r_sample_index - r_silence_start;
        run_len_tail = idx_next - start_eff;

        // A mid-stream run closes on the first loud sample; a trailing run
        // closes on the last sample when it is silent.
        close_mid  = r_in_silence && !silent && (CW'(run_len_mid) >= CW'(i_cfg.min_silence));
        close_tail = i_end_of_stream && silent
                     && (CW'(run_len_tail) >= CW'(i_cfg.min_silence));
        do_close   = close_mid || close_tail;
        run_end    = close_tail ? idx_next : r_sample_index;

        ce_sum = CW'(start_eff) + CW'(i_cfg.keep_silence);
        ce_sat = (ce_sum > IDX_MAX) ? IDX_MAX : ce_sum;
        ce     = W'(ce_sat);
        emit_close = do_close && (ce > r_resume_point);
        ce_out = (close_tail && (ce > idx_next)) ? idx_next : ce;

        end_wide   = CW'(run_end);
        resume_new = (end_wide >= CW'(i_cfg.keep_silence))
                     ? W'(end_wide - CW'(i_cfg.keep_silence)) : '0;
        resume_after = do_close ? resume_new : r_resume_point;
        any_after    = r_any_chunk_sent || emit_close;

        final_span  = resume_after < idx_next;
        emit_final  = i_end_of_stream && (final_span || !any_after);
        final_start = final_span ? resume_after : '0;

        close_c.seg_start  = OUT_BITS'(r_resume_point);
        close_c.seg_end    = OUT_BITS'(ce_out);
        close_c.last_chunk = i_end_of_stream && !emit_final;
        final_c.seg_start  = OUT_BITS'(final_start);
        final_c.seg_end    = OUT_BITS'(idx_next);
        final_c.last_chunk = 1'b1;

        o_push.count  = i_fire ? (2'(emit_close) + 2'(emit_final)) : 2'd0;
        o_push.first  = emit_close ? close_c : final_c;
        o_push.second = final_c;

        n_sample_index   = r_sample_index;
        n_in_silence     = r_in_silence;
        n_silence_start  = r_silence_start;
        n_resume_point   = r_resume_point;
        n_any_chunk_sent = r_any_chunk_sent;
        if (i_fire) begin
            if (i_end_of_stream) begin
                n_sample_index   = '0;
                n_in_silence     = 1'b0;
                n_silence_start  = '0;
                n_resume_point   = '0;
                n_any_chunk_sent = 1'b0;
            end else begin
                n_sample_index   = idx_next;
                n_in_silence     = silent;
                n_silence_start  = start_eff;
                n_resume_point   = resume_after;
                n_any_chunk_sent = any_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index   <= '0;
            r_in_silence     <= 1'b0;
            r_silence_start  <= '0;
            r_resume_point   <= '0;
            r_any_chunk_sent <= 1'b0;
        end else begin
            r_sample_index   <= n_sample_index;
            r_in_silence     <= n_in_silence;
            r_silence_start  <= n_silence_start;
            r_resume_point   <= n_resume_point;
            r_any_chunk_sent <= n_any_chunk_sent;
        end
    end

endmodule

/* design/ssseg_fifo.sv */
// Small result queue that takes up to two chunks per cycle and hands out one.
// Depends on ssseg_pkg for the chunk types and the queue depth.
module ssseg_fifo import ssseg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chunk_push i_push,
    output logic        o_room_two,
    output logic        o_valid,
    input  logic        i_ready,
    output t_chunk      o_chunk
);

    t_chunk                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_PTR_BITS:0]   r_count, n_count;
    logic                     pop;

    always_comb begin
        o_room_two = r_count <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2);
        o_valid    = r_count != '0;
        o_chunk    = r_mem[r_rd_ptr];
        pop        = o_valid && i_ready;
        n_wr_ptr   = r_wr_ptr + FIFO_PTR_BITS'(i_push.count);
        n_rd_ptr   = r_rd_ptr + FIFO_PTR_BITS'(pop);
        n_count    = r_count + (FIFO_PTR_BITS+1)'(i_push.count)
                     - (FIFO_PTR_BITS+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + 1'b1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* design/silence_split_segmenter.sv */
// Top level of the silence split segmenter.
// Depends on ssseg_pkg, ssseg_if, ssseg_core and ssseg_fifo.
//
// Usage: one signed 16-bit PCM sample arrives per beat on i_sample_ch, with
// end_of_stream set on the stream's last sample. Each beat on o_chunk_ch
// carries one chunk boundary pair [seg_start, seg_end) in sample indices;
// last_chunk marks the final chunk of a stream. A silent run of at least the
// minimum run length splits the stream, keeping the configured margin of
// silence on each side. A mid-stream chunk end may exceed the stream
// length and is clipped by the consumer.
//
// Throughput is one sample per cycle while the result queue has room for
// two more chunks. A sample produces zero, one or two chunks; two chunks
// drain at one per cycle, so a run of two-chunk samples is limited by the
// output port. An accepted sample is held in the input register and is
// processed once the queue has that room; its chunks then enter the
// four-entry result queue, which offers the first of them to the receiver.
//
// The sample port stalls only when the result queue cannot take two more
// chunks, so a stalled receiver backs up into the sample port and no chunk
// is ever dropped. Reset (synchronous, active low) empties the queue,
// clears the stream state and restores the register defaults. Configuration
// writes are expected only while the block is idle.
module silence_split_segmenter import ssseg_pkg::*; #(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    ssseg_sample_if.sink              i_sample_ch,
    ssseg_chunk_if.source             o_chunk_ch
);

    // Configuration registers, written through a plain write port.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= RST_THRESHOLD;
            r_cfg.min_silence  <= RST_MIN_SILENCE;
            r_cfg.keep_silence <= RST_KEEP_SILENCE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_THRESHOLD:    r_cfg.threshold    <= i_cfg_wdata[THR_BITS-1:0];
                CFG_MIN_SILENCE:  r_cfg.min_silence  <= i_cfg_wdata[LEN_BITS-1:0];
                CFG_KEEP_SILENCE: r_cfg.keep_silence <= i_cfg_wdata[LEN_BITS-1:0];
                default: begin
                    // Writes to unused indices are dropped.
                end
            endcase
        end
    end

    // Input register. The held sample is processed as soon as the result
    // queue has room for the two chunks it might produce.
    logic                          r_in_valid, n_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_in_eos;
    logic                          fire, accept, room_two;
    t_chunk_push                   push;
    t_chunk                        head;
    logic                          out_valid;

    always_comb begin
        fire   = r_in_valid && room_two;
        i_sample_ch.ready = !r_in_valid || fire;
        accept = i_sample_ch.valid && i_sample_ch.ready;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_sample <= i_sample_ch.audio_sample;
            r_in_eos    <= i_sample_ch.end_of_stream;
        end
    end

    ssseg_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_fire          (fire),
        .i_audio_sample  (r_in_sample),
        .i_end_of_stream (r_in_eos),
        .o_push          (push)
    );

    ssseg_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_room_two (room_two),
        .o_valid    (out_valid),
        .i_ready    (o_chunk_ch.ready),
        .o_chunk    (head)
    );

    assign o_chunk_ch.valid      = out_valid;
    assign o_chunk_ch.seg_start  = head.seg_start;
    assign o_chunk_ch.seg_end    = head.seg_end;
    assign o_chunk_ch.last_chunk = head.last_chunk;

endmodule

/* design/ssseg_chk.sv */
// Port-level checks of the silence split segmenter, bound to its top level.
// Depends on ssseg_pkg for the field widths.
module ssseg_chk import ssseg_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [OUT_BITS-1:0] i_seg_start,
    input logic [OUT_BITS-1:0] i_seg_end,
    input logic                i_last_chunk
);

    // A chunk that waits on the receiver stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_seg_start)
            && $stable(i_seg_end) && $stable(i_last_chunk))
        else $error("chunk changed while stalled");

    // The sample port only stalls when chunks are backed up.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("sample port stalled with empty result queue");

    // Reset leaves no chunk pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("chunk offered right after reset");

    // A stall on the sample port holds while the receiver does not drain.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready && !i_out_ready |=> !i_in_ready)
        else $error("sample stall released without a drained chunk");

endmodule

bind silence_split_segmenter ssseg_chk u_ssseg_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_sample_ch.ready),
    .i_out_valid  (o_chunk_ch.valid),
    .i_out_ready  (o_chunk_ch.ready),
    .i_seg_start  (o_chunk_ch.seg_start),
    .i_seg_end    (o_chunk_ch.seg_end),
    .i_last_chunk (o_chunk_ch.last_chunk)
);
